// File: rtl/btsm_pkg.sv
// Package for the bisection tree split/merge engine.
// Holds tree sizing constants and operation codes; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package btsm_pkg;
	localparam int MAX_DEPTH = 10;
	localparam int TREE_AW   = MAX_DEPTH + 1;
	localparam int TREE_SIZE = 1 << TREE_AW;
	localparam int CNT_W     = MAX_DEPTH + 1;
	localparam int DEP_W     = $clog2(MAX_DEPTH + 1);
	localparam int RANK_W    = MAX_DEPTH;
	localparam int FUNC_W    = 2;

	localparam logic [FUNC_W-1:0] FN_SPLIT  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_MERGE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REDUCE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_DECODE = 2'd3;
endpackage
`default_nettype wire

// File: rtl/btsm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module btsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/bisection_tree_split_merge_engine.sv
// Top level of the bisection tree split/merge engine: sequencer, edge walker, tree RAM.
// Depends on btsm_pkg and btsm_ram.
`timescale 1ns / 1ps
`default_nettype none
// The engine keeps a complete binary sum tree of 2048 counts in one RAM with a
// registered read port, and runs every operation as a sequence of single RAM
// accesses under a small state machine. After reset a clearing pass rebuilds
// the single-leaf tree; input transactions are held off until it ends, while
// configuration writes are taken at any time. One transaction is worked on at
// a time. A split makes its neighbour writes and a bit-by-bit edge-neighbour
// walk for each level climbed. A reduce visits each of the 1023 inner nodes
// with two reads and one write. A decode walks the tree level by level.
// Every operation ends with a read of the root count, and the result then
// sits in the output register until it is taken. The single RAM port pair
// is what sets the pace of all of these operations. Outside the clearing
// pass, counts only change on a reduce: splits and merges touch the leaf
// bitfield alone.
module bisection_tree_split_merge_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [btsm_pkg::FUNC_W-1:0]   func,
	input  wire logic [btsm_pkg::TREE_AW-1:0]  node_index,
	input  wire logic [btsm_pkg::DEP_W-1:0]    node_depth,
	input  wire logic [btsm_pkg::RANK_W-1:0]   leaf_index,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [btsm_pkg::CNT_W-1:0]    leaf_count,
	output logic      [btsm_pkg::TREE_AW-1:0]  found_index,
	output logic      [btsm_pkg::DEP_W-1:0]    found_depth,
	output logic                               status,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          vertex_ordering
);
	import btsm_pkg::*;

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_SW0  = 5'd2;
	localparam logic [4:0] S_EDGE = 5'd3;
	localparam logic [4:0] S_CHK  = 5'd4;
	localparam logic [4:0] S_SW1  = 5'd5;
	localparam logic [4:0] S_MRA  = 5'd6;
	localparam logic [4:0] S_MRB  = 5'd7;
	localparam logic [4:0] S_MRC  = 5'd8;
	localparam logic [4:0] S_MW1  = 5'd9;
	localparam logic [4:0] S_MW2  = 5'd10;
	localparam logic [4:0] S_RA   = 5'd11;
	localparam logic [4:0] S_RB   = 5'd12;
	localparam logic [4:0] S_RC   = 5'd13;
	localparam logic [4:0] S_DA   = 5'd14;
	localparam logic [4:0] S_DB   = 5'd15;
	localparam logic [4:0] S_DC   = 5'd16;
	localparam logic [4:0] S_RD   = 5'd17;
	localparam logic [4:0] S_RDW  = 5'd18;
	localparam logic [4:0] S_OUT  = 5'd19;

	localparam logic [DEP_W-1:0]   MAXD      = DEP_W'(MAX_DEPTH);
	localparam logic [DEP_W-1:0]   MAXD_M1   = DEP_W'(MAX_DEPTH - 1);
	localparam logic [CNT_W-1:0]   MERGE_LIM = CNT_W'(2);
	localparam logic [TREE_AW-1:0] ROOT      = TREE_AW'(1);

	logic [4:0]         state_q;
	logic               vo_q;
	logic               merge_q;
	logic               ok_q;
	logic [TREE_AW-1:0] clr_q;
	logic [TREE_AW-1:0] cur_q, par_q, dia_q, idx_q;
	logic [TREE_AW-1:0] l_q, r_q, e_q, s_q;
	logic [DEP_W-1:0]   d_q, b_q, dep_q;
	logic [RANK_W-1:0]  rank_q;
	logic [RANK_W-1:0]  red_q;
	logic [CNT_W-1:0]   lsum_q;

	// Tree RAM controls.
	logic               ram_we;
	logic [TREE_AW-1:0] ram_waddr, ram_raddr;
	logic [CNT_W-1:0]   ram_wdata, ram_rdata;

	btsm_ram #(
		.WIDTH(CNT_W),
		.DEPTH(TREE_SIZE)
	) u_tree (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The node is consistent when its highest set bit matches its stated depth.
	logic [DEP_W-1:0] msb;
	logic             node_ok;
	always_comb begin
		msb = '0;
		for (int k = 0; k < TREE_AW; k++) begin
			if (node_index[k]) begin
				msb = DEP_W'(k);
			end
		end
		node_ok = (node_index != '0) && (msb == node_depth) && (node_depth <= MAXD);
	end

	// One step of the edge-neighbour walk, consuming bit b-1 of the current node.
	logic [DEP_W-1:0]   bsel;
	logic               wbit;
	logic [TREE_AW-1:0] nl, nr, ne, ns;
	always_comb begin
		bsel = b_q - DEP_W'(1);
		wbit = cur_q[bsel];
		if (!wbit) begin
			nl = {s_q[TREE_AW-2:0], 1'b1};
			nr = {e_q[TREE_AW-2:0], e_q != '0};
			ne = vo_q ? {r_q[TREE_AW-2:0], r_q != '0} : {l_q[TREE_AW-2:0], l_q != '0};
			ns = {s_q[TREE_AW-2:0], 1'b0};
		end else begin
			nl = {e_q[TREE_AW-2:0], 1'b0};
			nr = {s_q[TREE_AW-2:0], 1'b0};
			ne = vo_q ? {l_q[TREE_AW-2:0], 1'b0} : {r_q[TREE_AW-2:0], 1'b0};
			ns = {s_q[TREE_AW-2:0], 1'b1};
		end
	end

	// Leaf addresses: the right child of a node pushed down to the bitfield level,
	// and the right child of a node's parent (or the right child of the diamond parent).
	logic [DEP_W-1:0]   split_sh, merge_sh;
	logic [TREE_AW-1:0] split_addr, merge_addr_a, merge_addr_b;
	always_comb begin
		split_sh     = MAXD_M1 - d_q;
		merge_sh     = MAXD - dep_q;
		split_addr   = TREE_AW'({cur_q, 1'b1} << split_sh);
		merge_addr_a = (idx_q | ROOT) << merge_sh;
		merge_addr_b = TREE_AW'({dia_q, 1'b1} << merge_sh);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = CNT_W'($onehot(clr_q));
			end
			S_SW0, S_SW1: begin
				ram_we    = 1'b1;
				ram_waddr = split_addr;
				ram_wdata = CNT_W'(1);
			end
			S_MRA: ram_raddr = par_q;
			S_MRB: ram_raddr = dia_q;
			S_MW1: begin
				ram_we    = 1'b1;
				ram_waddr = merge_addr_a;
			end
			S_MW2: begin
				ram_we    = 1'b1;
				ram_waddr = merge_addr_b;
			end
			S_RA: ram_raddr = {red_q, 1'b0};
			S_RB: ram_raddr = {red_q, 1'b1};
			S_RC: begin
				ram_we    = 1'b1;
				ram_waddr = TREE_AW'(red_q);
				ram_wdata = lsum_q + ram_rdata;
			end
			S_DA: ram_raddr = cur_q;
			S_DB: ram_raddr = {cur_q[TREE_AW-2:0], 1'b0};
			S_RD: ram_raddr = ROOT;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			vo_q      <= 1'b0;
			out_valid <= 1'b0;
			merge_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vo_q <= vertex_ordering;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + TREE_AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						idx_q       <= node_index;
						dep_q       <= node_depth;
						rank_q      <= leaf_index;
						found_index <= '0;
						found_depth <= '0;
						status      <= 1'b0;
						unique case (func)
							FN_SPLIT: begin
								if (!node_ok || node_depth >= MAXD) begin
									status  <= 1'b1;
									state_q <= S_RD;
								end else begin
									cur_q   <= node_index;
									d_q     <= node_depth;
									merge_q <= 1'b0;
									state_q <= S_SW0;
								end
							end
							FN_MERGE: begin
								if (!node_ok || node_index <= ROOT) begin
									status  <= 1'b1;
									state_q <= S_RD;
								end else begin
									par_q   <= node_index >> 1;
									cur_q   <= node_index >> 1;
									b_q     <= node_depth - DEP_W'(1);
									l_q     <= '0;
									r_q     <= '0;
									e_q     <= '0;
									s_q     <= ROOT;
									merge_q <= 1'b1;
									state_q <= S_EDGE;
								end
							end
							FN_REDUCE: begin
								red_q   <= '1;
								state_q <= S_RA;
							end
							FN_DECODE: begin
								cur_q   <= ROOT;
								d_q     <= '0;
								state_q <= S_DA;
							end
							default: ;
						endcase
					end
				end
				S_SW0: begin
					b_q     <= d_q;
					l_q     <= '0;
					r_q     <= '0;
					e_q     <= '0;
					s_q     <= ROOT;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if (b_q == '0) begin
						cur_q <= e_q;
						if (merge_q) begin
							dia_q   <= (e_q == '0) ? par_q : e_q;
							state_q <= S_MRA;
						end else begin
							state_q <= S_CHK;
						end
					end else begin
						l_q <= nl;
						r_q <= nr;
						e_q <= ne;
						s_q <= ns;
						b_q <= bsel;
					end
				end
				S_CHK: begin
					state_q <= (cur_q > ROOT && d_q != '0) ? S_SW1 : S_RD;
				end
				S_SW1: begin
					cur_q   <= cur_q >> 1;
					d_q     <= d_q - DEP_W'(1);
					state_q <= S_SW0;
				end
				S_MRA: state_q <= S_MRB;
				S_MRB: begin
					ok_q    <= (ram_rdata <= MERGE_LIM);
					state_q <= S_MRC;
				end
				S_MRC: begin
					if (ok_q && ram_rdata <= MERGE_LIM) begin
						state_q <= S_MW1;
					end else begin
						status  <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_MW1: state_q <= S_MW2;
				S_MW2: state_q <= S_RD;
				S_RA:  state_q <= S_RB;
				S_RB: begin
					lsum_q  <= ram_rdata;
					state_q <= S_RC;
				end
				S_RC: begin
					// Descending order finishes both children before their parent.
					if (red_q == RANK_W'(1)) begin
						state_q <= S_RD;
					end else begin
						red_q   <= red_q - RANK_W'(1);
						state_q <= S_RA;
					end
				end
				S_DA: state_q <= S_DB;
				S_DB: begin
					if (d_q == '0 && CNT_W'(rank_q) >= ram_rdata) begin
						status  <= 1'b1;
						state_q <= S_RD;
					end else if (d_q >= MAXD || ram_rdata <= CNT_W'(1)) begin
						found_index <= cur_q;
						found_depth <= d_q;
						state_q     <= S_RD;
					end else begin
						state_q <= S_DC;
					end
				end
				S_DC: begin
					if (CNT_W'(rank_q) < ram_rdata) begin
						cur_q <= {cur_q[TREE_AW-2:0], 1'b0};
					end else begin
						rank_q <= rank_q - RANK_W'(ram_rdata);
						cur_q  <= {cur_q[TREE_AW-2:0], 1'b1};
					end
					d_q     <= d_q + DEP_W'(1);
					state_q <= S_DA;
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					leaf_count <= ram_rdata;
					out_valid  <= 1'b1;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
